// ----- rtl/core/vmt_pkg.sv -----
// Shared types and constants for the vertex matrix transform block.
package vmt_pkg;

   // Matrix dimension and fixed-point format.
   localparam int DIM       = 4;
   localparam int IDX_W     = $clog2(DIM);
   localparam int FIX_W     = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * FIX_W;
   localparam int ACC_W     = PROD_W + IDX_W;
   localparam int Q_W       = ACC_W - FRAC_BITS;

   // Stream payload widths.
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = DIM * FIX_W;

   typedef logic signed [FIX_W-1:0]  fix_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // Item kinds carried on the request tuser bit.
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_XFORM = 1'b1
   } op_type;

   // One in Q16.16 and the saturation bounds.
   localparam fix_type FIX_ONE = fix_type'(1 << FRAC_BITS);
   localparam fix_type FIX_MAX = fix_type'(32'h7FFF_FFFF);
   localparam fix_type FIX_MIN = fix_type'(32'h8000_0000);
   localparam acc_type ACC_HALF = acc_type'(1) << (FRAC_BITS - 1);

   // What travels from one cell to the next in each cycle.
   typedef struct packed {
      logic                    valid;
      op_type                  op;
      logic [2*IDX_W-1:0]      entry_index;
      fix_type                 entry_value;
      fix_type [DIM-1:0]       vec;
      acc_type [DIM-1:0]       acc;
   } beat_type;

endpackage

// ----- rtl/core/vmt_cell.sv -----
// One column cell: holds a matrix column, multiplies it by one vector component, accumulates.
module vmt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [vmt_pkg::IDX_W-1:0] col,
   input  vmt_pkg::beat_type         beat_in,
   output vmt_pkg::beat_type         beat_out
);

   vmt_pkg::fix_type  col_ff  [vmt_pkg::DIM];
   vmt_pkg::fix_type  col_in  [vmt_pkg::DIM];
   vmt_pkg::prod_type prod_ff [vmt_pkg::DIM];
   vmt_pkg::prod_type prod_in [vmt_pkg::DIM];
   vmt_pkg::beat_type mid_ff;
   vmt_pkg::beat_type mid_in;
   vmt_pkg::beat_type out_ff;
   vmt_pkg::beat_type out_in;
   logic              hit;

   // Stage one: apply a write aimed at this column and form the row products.
   always_comb begin
      hit = beat_in.valid && (beat_in.op == vmt_pkg::OP_WRITE) &&
            (beat_in.entry_index[vmt_pkg::IDX_W-1:0] == col);
      for (int r = 0; r < vmt_pkg::DIM; r++) begin
         if (hit && (beat_in.entry_index[2*vmt_pkg::IDX_W-1:vmt_pkg::IDX_W] ==
                     vmt_pkg::IDX_W'(r))) begin
            col_in[r] = beat_in.entry_value;
         end else begin
            col_in[r] = col_ff[r];
         end
         prod_in[r] = $signed(col_ff[r]) * $signed(beat_in.vec[col]);
      end
      mid_in = beat_in;
   end

   // Stage two: add the products to the running row sums.
   always_comb begin
      out_in = mid_ff;
      for (int r = 0; r < vmt_pkg::DIM; r++) begin
         out_in.acc[r] = mid_ff.acc[r] + vmt_pkg::ACC_W'(prod_ff[r]);
      end
   end

   // Matrix column, reset to the matching column of the identity.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < vmt_pkg::DIM; r++) begin
            col_ff[r] <= (vmt_pkg::IDX_W'(r) == col) ? vmt_pkg::FIX_ONE : '0;
         end
      end else if (en) begin
         col_ff <= col_in;
      end
   end

   // Pipeline registers: valid bits are reset, the payload only follows the chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         mid_ff.valid <= mid_in.valid;
         out_ff.valid <= out_in.valid;
      end
      if (en) begin
         prod_ff            <= prod_in;
         mid_ff.op          <= mid_in.op;
         mid_ff.entry_index <= mid_in.entry_index;
         mid_ff.entry_value <= mid_in.entry_value;
         mid_ff.vec         <= mid_in.vec;
         mid_ff.acc         <= mid_in.acc;
         out_ff.op          <= out_in.op;
         out_ff.entry_index <= out_in.entry_index;
         out_ff.entry_value <= out_in.entry_value;
         out_ff.vec         <= out_in.vec;
         out_ff.acc         <= out_in.acc;
      end
   end

   assign beat_out = out_ff;

endmodule

// ----- rtl/core/vmt_round.sv -----
// Output stage: rounds and saturates the row sums and holds the result beat.
module vmt_round (
   input  logic                               clock,
   input  logic                               reset,
   input  vmt_pkg::beat_type                  beat_in,
   output logic                               en,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vmt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser
);

   vmt_pkg::acc_type                  rnd_w [vmt_pkg::DIM];
   logic signed [vmt_pkg::Q_W-1:0]    q_w   [vmt_pkg::DIM];
   logic [vmt_pkg::DIM-1:0]           sat_w;
   vmt_pkg::fix_type [vmt_pkg::DIM-1:0] res_in;
   vmt_pkg::fix_type [vmt_pkg::DIM-1:0] res_ff;
   logic                              ovf_in;
   logic                              ovf_ff;
   logic                              valid_in;
   logic                              valid_ff;
   logic                              tail_busy;

   // Round half up to Q16.16 and clamp to 32 bits.
   always_comb begin
      for (int r = 0; r < vmt_pkg::DIM; r++) begin
         rnd_w[r] = beat_in.acc[r] + vmt_pkg::ACC_HALF;
         q_w[r]   = rnd_w[r][vmt_pkg::ACC_W-1:vmt_pkg::FRAC_BITS];
         sat_w[r] = !((&q_w[r][vmt_pkg::Q_W-1:vmt_pkg::FIX_W-1]) ||
                      !(|q_w[r][vmt_pkg::Q_W-1:vmt_pkg::FIX_W-1]));
         if (sat_w[r]) begin
            res_in[r] = q_w[r][vmt_pkg::Q_W-1] ? vmt_pkg::FIX_MIN : vmt_pkg::FIX_MAX;
         end else begin
            res_in[r] = q_w[r][vmt_pkg::FIX_W-1:0];
         end
      end
      ovf_in = |sat_w;
   end

   // The chain moves unless a finished transform waits on a full output register that rsp_tready does not drain.
   always_comb begin
      tail_busy = beat_in.valid && (beat_in.op == vmt_pkg::OP_XFORM);
      en        = !tail_busy || !valid_ff || rsp_tready;
      if (tail_busy && en) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_busy && en) begin
         res_ff <= res_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff;
   assign rsp_tuser  = ovf_ff;

endmodule

// ----- rtl/core/vertex_matrix_transform.sv -----
// Top level of the 4x4 matrix times vector transform block.
// The block keeps a 4x4 Q16.16 matrix, reset to the identity, spread over a chain of four
// column cells; each cell holds one matrix column and has two stages (multiply, accumulate).
// One beat is taken every cycle while the chain is not stalled, writes and transforms alike;
// a transform's result, after both stages of each cell, is registered by the rounding stage. A
// matrix write travels down the chain in order with the transforms, so every transform sees
// exactly the writes accepted before it. Only an output beat held by rsp_tready low, with
// another finished transform behind it, stalls the chain and drops req_tready.
module vertex_matrix_transform (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // entry_index[3:0], entry_value[35:4], vec_x[67:36], vec_y[99:68],
   // vec_z[131:100], vec_w[163:132], zero fill [167:164]
   input  logic [vmt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op[0]: 0 writes a matrix entry, 1 transforms the vector
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
   output logic [vmt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // overflow[0]
   output logic                               rsp_tuser
);

   vmt_pkg::beat_type chain [vmt_pkg::DIM+1];
   logic              en;

   // Unpack the request beat into the head of the chain.
   always_comb begin
      chain[0].valid       = req_tvalid;
      chain[0].op          = vmt_pkg::op_type'(req_tuser);
      chain[0].entry_index = req_tdata[3:0];
      chain[0].entry_value = req_tdata[35:4];
      chain[0].vec[0]      = req_tdata[67:36];
      chain[0].vec[1]      = req_tdata[99:68];
      chain[0].vec[2]      = req_tdata[131:100];
      chain[0].vec[3]      = req_tdata[163:132];
      chain[0].acc         = '0;
   end

   // One cell per matrix column.
   for (genvar g = 0; g < vmt_pkg::DIM; g++) begin : g_cell
      vmt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .col      (vmt_pkg::IDX_W'(g)),
         .beat_in  (chain[g]),
         .beat_out (chain[g+1])
      );
   end

   vmt_round u_round (
      .clock      (clock),
      .reset      (reset),
      .beat_in    (chain[vmt_pkg::DIM]),
      .en         (en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = en;

   // The chain only stops while a result is held at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("chain stalled without a held result");

   // A stalled chain keeps its tail beat.
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(chain[vmt_pkg::DIM]))
      else $error("chain tail changed during a stall");

   // The overflow flag comes with at least one clamped component.
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[31:0]   == vmt_pkg::FIX_MAX || rsp_tdata[31:0]   == vmt_pkg::FIX_MIN ||
          rsp_tdata[63:32]  == vmt_pkg::FIX_MAX || rsp_tdata[63:32]  == vmt_pkg::FIX_MIN ||
          rsp_tdata[95:64]  == vmt_pkg::FIX_MAX || rsp_tdata[95:64]  == vmt_pkg::FIX_MIN ||
          rsp_tdata[127:96] == vmt_pkg::FIX_MAX || rsp_tdata[127:96] == vmt_pkg::FIX_MIN))
      else $error("overflow set without a saturated component");

endmodule
